// ===== rtl/eth_ipv4_tcp_header_checker_top_assert.svh =====
// assertion macros for the header checker top level
// needs nothing else; taken in by the top level with an include line
`ifndef ETH_IPV4_TCP_HEADER_CHECKER_TOP_ASSERT_SVH
`define ETH_IPV4_TCP_HEADER_CHECKER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every rising edge out of reset
`define EITC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eitc assertion failed");

// next-cycle implication
`define EITC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eitc assertion failed");

`else

`define EITC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define EITC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/eitc_pkg.sv =====
// types and constants shared by the header checker modules
// no dependencies
`timescale 1ns / 1ps

package eitc_pkg;

  // byte positions within the frame
  localparam int ETH_DST_END   = 6;
  localparam int ETH_SRC_END   = 12;
  localparam int ETH_HDR_LEN   = 14;
  localparam int IP_PROTO_OFS  = 23;
  localparam int IP_ADDR_OFS   = 26;
  localparam int IP_ADDR_END   = 34;

  // byte positions within the tcp header
  localparam int TCP_PORT_BYTES = 4;
  localparam int TCP_OFF_OFS    = 12;
  localparam int TCP_FLAGS_OFS  = 13;

  // shortest legal header, in 32-bit words
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  localparam logic [15:0] CSUM_ONES = 16'hffff;

  localparam logic [7:0] TCP_FIN = 8'h01;
  localparam logic [7:0] TCP_PSH = 8'h08;
  localparam logic [7:0] TCP_URG = 8'h20;
  localparam logic [7:0] XMAS_MASK = TCP_FIN | TCP_PSH | TCP_URG;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_IP_SHORT  = 2'd1,
    STATUS_TCP_SHORT = 2'd2,
    STATUS_TRUNC     = 2'd3
  } status_e;

  // frame state as it stands once the current byte is taken in
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] eth_type;
    logic [3:0]  ip_words;
    logic [7:0]  ip_proto;
    logic [63:0] ip_addr;
    logic [31:0] ports;
    logic [3:0]  tcp_off;
    logic [7:0]  flags;
    logic [15:0] sum;
    logic        flags_seen;
    logic        hdr_seen;
  } frame_state_t;

  typedef struct packed {
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] eth_type;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    status_e     status;
    logic        csum_bad;
    logic        xmas_scan;
    logic        null_scan;
  } result_t;

endpackage

// ===== rtl/eitc_ifs.sv =====
// valid/ready channel interfaces: frame bytes in, header results out
// no dependencies
`timescale 1ns / 1ps

interface eitc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface eitc_result_if;
  logic        valid;
  logic        ready;
  logic [47:0] src_mac;
  logic [47:0] dst_mac;
  logic [15:0] eth_type;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  ip_protocol;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [1:0]  status;
  logic        csum_bad;
  logic        xmas_scan;
  logic        null_scan;

  modport source (
    output valid, output src_mac, output dst_mac, output eth_type, output src_ip,
    output dst_ip, output ip_protocol, output src_port, output dst_port,
    output status, output csum_bad, output xmas_scan, output null_scan,
    input ready
  );
  modport sink (
    input valid, input src_mac, input dst_mac, input eth_type, input src_ip,
    input dst_ip, input ip_protocol, input src_port, input dst_port,
    input status, input csum_bad, input xmas_scan, input null_scan,
    output ready
  );
endinterface

// ===== rtl/eitc_capture.sv =====
// per-byte field capture, byte counter and ip header checksum accumulator
// depends on eitc_pkg
`timescale 1ns / 1ps

module eitc_capture import eitc_pkg::*; #(
  parameter int MAX_FRAME = 2048
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_i,
  output frame_state_t state_o,
  output logic         at_start_o
);

  localparam int OW = $clog2(MAX_FRAME + 1);

  logic [OW-1:0] offset_q, offset_d;
  logic [47:0]   dst_mac_q, dst_mac_d;
  logic [47:0]   src_mac_q, src_mac_d;
  logic [15:0]   eth_type_q, eth_type_d;
  logic [3:0]    ip_words_q, ip_words_d;
  logic [7:0]    ip_proto_q, ip_proto_d;
  logic [63:0]   ip_addr_q, ip_addr_d;
  logic [31:0]   ports_q, ports_d;
  logic [3:0]    tcp_off_q, tcp_off_d;
  logic [7:0]    flags_q, flags_d;
  logic [15:0]   sum_q, sum_d;
  logic [7:0]    hold_q, hold_d;
  logic          flags_seen_q, flags_seen_d;

  logic          in_range;
  logic          past_eth;
  logic [OW-1:0] rel;
  logic [5:0]    ip_len;
  logic [6:0]    tcp_start;
  logic [OW-1:0] tcp_rel;
  logic          in_tcp;
  logic [16:0]   sum_raw;

  assign in_range  = offset_q < OW'(MAX_FRAME);
  assign past_eth  = offset_q >= OW'(ETH_HDR_LEN);
  assign rel       = offset_q - OW'(ETH_HDR_LEN);
  // header length takes effect on the very byte that carries it
  assign ip_words_d = (in_range && (offset_q == OW'(ETH_HDR_LEN))) ? data_byte_i[3:0]
                                                                   : ip_words_q;
  assign ip_len    = {ip_words_d, 2'b00};
  assign tcp_start = 7'(ETH_HDR_LEN) + {1'b0, ip_len};
  assign tcp_rel   = offset_q - OW'(tcp_start);
  assign in_tcp    = past_eth && (ip_words_d >= MIN_HDR_WORDS) && (offset_q >= OW'(tcp_start));
  assign sum_raw   = {1'b0, sum_q} + {1'b0, hold_q, data_byte_i};

  always_comb begin
    offset_d     = offset_q;
    dst_mac_d    = dst_mac_q;
    src_mac_d    = src_mac_q;
    eth_type_d   = eth_type_q;
    ip_proto_d   = ip_proto_q;
    ip_addr_d    = ip_addr_q;
    ports_d      = ports_q;
    tcp_off_d    = tcp_off_q;
    flags_d      = flags_q;
    sum_d        = sum_q;
    hold_d       = hold_q;
    flags_seen_d = flags_seen_q;
    if (in_range) begin
      offset_d = offset_q + OW'(1);
      if (offset_q < OW'(ETH_DST_END)) begin
        dst_mac_d = {dst_mac_q[39:0], data_byte_i};
      end else if (offset_q < OW'(ETH_SRC_END)) begin
        src_mac_d = {src_mac_q[39:0], data_byte_i};
      end else if (offset_q < OW'(ETH_HDR_LEN)) begin
        eth_type_d = {eth_type_q[7:0], data_byte_i};
      end
      if (offset_q == OW'(IP_PROTO_OFS)) begin
        ip_proto_d = data_byte_i;
      end
      if ((offset_q >= OW'(IP_ADDR_OFS)) && (offset_q < OW'(IP_ADDR_END))) begin
        ip_addr_d = {ip_addr_q[55:0], data_byte_i};
      end
      // checksum over the ip header, high byte held until its partner arrives
      if (past_eth && (rel < OW'(ip_len))) begin
        if (!rel[0]) begin
          hold_d = data_byte_i;
        end else if (sum_raw > {1'b0, CSUM_ONES}) begin
          sum_d = 16'(sum_raw - {1'b0, CSUM_ONES});
        end else begin
          sum_d = sum_raw[15:0];
        end
      end
      if (in_tcp) begin
        if (tcp_rel < OW'(TCP_PORT_BYTES)) begin
          ports_d = {ports_q[23:0], data_byte_i};
        end else if (tcp_rel == OW'(TCP_OFF_OFS)) begin
          tcp_off_d = data_byte_i[7:4];
        end else if (tcp_rel == OW'(TCP_FLAGS_OFS)) begin
          flags_d      = data_byte_i;
          flags_seen_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_o.dst_mac    = dst_mac_d;
    state_o.src_mac    = src_mac_d;
    state_o.eth_type   = eth_type_d;
    state_o.ip_words   = ip_words_d;
    state_o.ip_proto   = ip_proto_d;
    state_o.ip_addr    = ip_addr_d;
    state_o.ports      = ports_d;
    state_o.tcp_off    = tcp_off_d;
    state_o.flags      = flags_d;
    state_o.sum        = sum_d;
    state_o.flags_seen = flags_seen_d;
    state_o.hdr_seen   = offset_d > OW'(ETH_HDR_LEN);
  end

  assign at_start_o = offset_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      dst_mac_q    <= '0;
      src_mac_q    <= '0;
      eth_type_q   <= '0;
      ip_words_q   <= '0;
      ip_proto_q   <= '0;
      ip_addr_q    <= '0;
      ports_q      <= '0;
      tcp_off_q    <= '0;
      flags_q      <= '0;
      sum_q        <= CSUM_ONES;
      hold_q       <= '0;
      flags_seen_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        // frame done, start the next one from a clean slate
        offset_q     <= '0;
        dst_mac_q    <= '0;
        src_mac_q    <= '0;
        eth_type_q   <= '0;
        ip_words_q   <= '0;
        ip_proto_q   <= '0;
        ip_addr_q    <= '0;
        ports_q      <= '0;
        tcp_off_q    <= '0;
        flags_q      <= '0;
        sum_q        <= CSUM_ONES;
        hold_q       <= '0;
        flags_seen_q <= 1'b0;
      end else begin
        offset_q     <= offset_d;
        dst_mac_q    <= dst_mac_d;
        src_mac_q    <= src_mac_d;
        eth_type_q   <= eth_type_d;
        ip_words_q   <= ip_words_d;
        ip_proto_q   <= ip_proto_d;
        ip_addr_q    <= ip_addr_d;
        ports_q      <= ports_d;
        tcp_off_q    <= tcp_off_d;
        flags_q      <= flags_d;
        sum_q        <= sum_d;
        hold_q       <= hold_d;
        flags_seen_q <= flags_seen_d;
      end
    end
  end

endmodule

// ===== rtl/eitc_verdict.sv =====
// end-of-frame status, checksum and scan classification
// depends on eitc_pkg
`timescale 1ns / 1ps

module eitc_verdict import eitc_pkg::*; (
  input  frame_state_t state_i,
  output result_t      result_o
);

  status_e status;

  always_comb begin
    priority if (!state_i.hdr_seen) begin
      status = STATUS_TRUNC;
    end else if (state_i.ip_words < MIN_HDR_WORDS) begin
      status = STATUS_IP_SHORT;
    end else if (!state_i.flags_seen) begin
      status = STATUS_TRUNC;
    end else if (state_i.tcp_off < MIN_HDR_WORDS) begin
      status = STATUS_TCP_SHORT;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    result_o.src_mac     = state_i.src_mac;
    result_o.dst_mac     = state_i.dst_mac;
    result_o.eth_type    = state_i.eth_type;
    result_o.src_ip      = state_i.ip_addr[63:32];
    result_o.dst_ip      = state_i.ip_addr[31:0];
    result_o.ip_protocol = state_i.ip_proto;
    result_o.src_port    = state_i.ports[31:16];
    result_o.dst_port    = state_i.ports[15:0];
    result_o.status      = status;
    // flags only mean something for a well-formed frame
    result_o.csum_bad    = (status == STATUS_OK) && (state_i.sum != CSUM_ONES);
    result_o.xmas_scan   = (status == STATUS_OK) && ((state_i.flags & XMAS_MASK) == XMAS_MASK);
    result_o.null_scan   = (status == STATUS_OK) && (state_i.flags == 8'h00);
  end

endmodule

// ===== rtl/eth_ipv4_tcp_header_checker_top.sv =====
// a byte is registered in the byte stage on acceptance and worked on from there;
// the result for a frame is loaded into the result register when its last byte
// leaves the byte stage, and is held there until taken
// throughput: one byte per cycle, stalling only while a finished result waits
// and the byte in hand is the last of the next frame
// reset: asynchronous active low, clears the byte stage, result slot and all
// header state; no clearing pass is needed
`timescale 1ns / 1ps
`include "eth_ipv4_tcp_header_checker_top_assert.svh"

module eth_ipv4_tcp_header_checker_top import eitc_pkg::*; #(
  parameter int MAX_FRAME = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  eitc_byte_if.sink   in_i,
  eitc_result_if.source res_o
);

  // byte stage: holds one accepted transaction for the capture logic
  logic       byte_vld_q;
  logic [7:0] byte_q;
  logic       last_q;

  // result slot
  logic       res_vld_q, res_vld_d;
  result_t    res_q;

  logic         slot_free;
  logic         advance;
  frame_state_t frame_state;
  result_t      verdict;
  logic         at_start;

  // a non-final byte never touches the result slot, so it always moves on;
  // the final byte waits until the slot is empty or being emptied
  assign slot_free = !res_vld_q || res_o.ready;
  assign advance   = byte_vld_q && (!last_q || slot_free);
  assign in_i.ready = !byte_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      byte_vld_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last;
    end
  end

  eitc_capture #(
    .MAX_FRAME (MAX_FRAME)
  ) u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (byte_q),
    .last_i      (last_q),
    .state_o     (frame_state),
    .at_start_o  (at_start)
  );

  eitc_verdict u_verdict (
    .state_i  (frame_state),
    .result_o (verdict)
  );

  // result register: loaded on the final byte, held until taken
  assign res_vld_d = (advance && last_q) || (res_vld_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= verdict;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.src_mac     = res_q.src_mac;
  assign res_o.dst_mac     = res_q.dst_mac;
  assign res_o.eth_type    = res_q.eth_type;
  assign res_o.src_ip      = res_q.src_ip;
  assign res_o.dst_ip      = res_q.dst_ip;
  assign res_o.ip_protocol = res_q.ip_protocol;
  assign res_o.src_port    = res_q.src_port;
  assign res_o.dst_port    = res_q.dst_port;
  assign res_o.status      = res_q.status;
  assign res_o.csum_bad    = res_q.csum_bad;
  assign res_o.xmas_scan   = res_q.xmas_scan;
  assign res_o.null_scan   = res_q.null_scan;

  // a final byte facing a full, stalled result slot must hold off new input
  `EITC_ASSERT_NOW(a_hold_on_full_slot, clk_i, rst_ni,
    byte_vld_q && last_q && res_vld_q && !res_o.ready, !in_i.ready)
  // the slot only fills from a final byte
  `EITC_ASSERT_NOW(a_fill_from_last, clk_i, rst_ni,
    $rose(res_vld_q), $past(advance && last_q))
  // a frame that ends restarts the byte count
  `EITC_ASSERT_NEXT(a_restart_after_last, clk_i, rst_ni,
    advance && last_q, at_start)
  // scan and checksum flags only accompany an ok status
  `EITC_ASSERT_NOW(a_flags_need_ok, clk_i, rst_ni,
    res_vld_q && (res_q.status != STATUS_OK),
    !res_q.csum_bad && !res_q.xmas_scan && !res_q.null_scan)

endmodule
